// ----- hw/rtl/tetu_pkg.sv -----
`timescale 1ns / 1ps
package tetu_pkg;

   localparam int UnitWidth = 32;
   localparam int CpWidth = 21;
   localparam int MaxUnits = 4;

   typedef enum logic [2:0] {
      ENC_ASCII  = 3'd0,
      ENC_UTF8   = 3'd1,
      ENC_UTF16  = 3'd2,
      ENC_UTF32  = 3'd3,
      ENC_CP1252 = 3'd4
   } enc_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_UNENCODE  = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   localparam logic [0:0] CSR_SOURCE = 1'b0;
   localparam logic [0:0] CSR_TARGET = 1'b1;

   // Decoder outcome handed to the encoder stage.
   typedef struct packed {
      logic              emit;     // a result is produced for this item
      logic              done;     // code point complete, encode it
      status_type        status;   // error code when emit && !done
      logic [CpWidth-1:0] cp;
   } dec_type;

   // CP1252 0x80-0x9F to code point, zero where undefined.
   function automatic logic [15:0] cp1252_hi(input logic [4:0] idx);
      logic [15:0] r;
      case (idx)
         5'd0:  r = 16'h20ac; 5'd2:  r = 16'h201a; 5'd3:  r = 16'h0192;
         5'd4:  r = 16'h201e; 5'd5:  r = 16'h2026; 5'd6:  r = 16'h2020;
         5'd7:  r = 16'h2021; 5'd8:  r = 16'h02c6; 5'd9:  r = 16'h2030;
         5'd10: r = 16'h0160; 5'd11: r = 16'h2039; 5'd12: r = 16'h0152;
         5'd14: r = 16'h017d; 5'd17: r = 16'h2018; 5'd18: r = 16'h2019;
         5'd19: r = 16'h201c; 5'd20: r = 16'h201d; 5'd21: r = 16'h2022;
         5'd22: r = 16'h2013; 5'd23: r = 16'h2014; 5'd24: r = 16'h02dc;
         5'd25: r = 16'h2122; 5'd26: r = 16'h0161; 5'd27: r = 16'h203a;
         5'd28: r = 16'h0153; 5'd30: r = 16'h017e; 5'd31: r = 16'h0178;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/tetu_encoder.sv -----
`timescale 1ns / 1ps
module tetu_encoder (
   input  logic [2:0]                      target,
   input  tetu_pkg::dec_type               dec,
   output logic [2:0]                      count,    // units minus one
   output logic [tetu_pkg::MaxUnits-1:0][tetu_pkg::UnitWidth-1:0] units,
   output tetu_pkg::status_type            status
);
   import tetu_pkg::*;

   logic [CpWidth-1:0] cp;
   logic [CpWidth-1:0] sub;
   logic               fail;
   logic [4:0]         hit;
   logic               found;

   assign cp  = dec.cp;
   assign sub = cp - CpWidth'(20'h10000);

   always_comb begin
      found = 1'b0;
      hit   = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (cp1252_hi(5'(i)) != 16'h0 && CpWidth'(cp1252_hi(5'(i))) == cp) begin
            found = 1'b1;
            hit   = 5'(i);
         end
      end
   end

   always_comb begin
      units = '0;
      count = 3'd0;
      fail  = 1'b0;
      case (target)
         ENC_ASCII: begin
            fail = cp > 21'h7f;
            units[0] = UnitWidth'(cp);
         end
         ENC_UTF8: begin
            if (cp <= 21'h7f) begin
               units[0] = UnitWidth'(cp);
            end else if (cp <= 21'h7ff) begin
               count = 3'd1;
               units[0] = UnitWidth'({3'b110, cp[10:6]});
               units[1] = UnitWidth'({2'b10, cp[5:0]});
            end else if (cp <= 21'hffff) begin
               count = 3'd2;
               units[0] = UnitWidth'({4'b1110, cp[15:12]});
               units[1] = UnitWidth'({2'b10, cp[11:6]});
               units[2] = UnitWidth'({2'b10, cp[5:0]});
            end else begin
               fail  = cp > 21'h10ffff;
               count = 3'd3;
               units[0] = UnitWidth'({5'b11110, cp[20:18]});
               units[1] = UnitWidth'({2'b10, cp[17:12]});
               units[2] = UnitWidth'({2'b10, cp[11:6]});
               units[3] = UnitWidth'({2'b10, cp[5:0]});
            end
         end
         ENC_UTF16: begin
            fail = cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff);
            if (cp <= 21'hffff) begin
               units[0] = UnitWidth'(cp);
            end else begin
               count = 3'd1;
               units[0] = UnitWidth'({6'b110110, sub[19:10]});
               units[1] = UnitWidth'({6'b110111, sub[9:0]});
            end
         end
         ENC_UTF32: begin
            fail = cp > 21'h10ffff;
            units[0] = UnitWidth'(cp);
         end
         ENC_CP1252: begin
            if (cp <= 21'h7f || (cp >= 21'ha0 && cp <= 21'hff)) begin
               units[0] = UnitWidth'(cp);
            end else begin
               fail = !found;
               units[0] = UnitWidth'({3'b100, hit});
            end
         end
         default: fail = 1'b1;
      endcase
      status = ST_OK;
      if (!dec.done) begin
         status = dec.status;
      end else if (fail) begin
         status = ST_UNENCODE;
      end
      if (status != ST_OK) begin
         units = '0;
         count = 3'd0;
      end
   end

endmodule

// ----- hw/rtl/text_encoding_transcoder_unit.sv -----
`timescale 1ns / 1ps
// Streaming transcoder: one source code unit per item in, one to four target
// units out (error results are a single unit, last_of_char set, out_unit zero).
// Decoding is done at the input and the encoded character is held in a result
// register, so the first unit of a character is offered the cycle after the
// item that completes it. A new item is taken in the cycle the last held unit
// leaves. Single-unit characters stream at one per cycle when rsp_stall is low;
// a longer character stalls input until its last unit leaves. Writing either
// csr register drops any partial character; write only while idle.
module text_encoding_transcoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_in_unit,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_unit,
   output logic        rsp_last_of_char,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [2:0]  csr_data
);
   import tetu_pkg::*;

   logic [2:0]  src_ff, tgt_ff;
   logic [CpWidth-1:0] part_ff, part_in;
   logic [1:0]  pend_ff, pend_in;

   logic        hold_ff;
   logic [2:0]  idx_ff, cnt_ff;
   logic [MaxUnits-1:0][UnitWidth-1:0] buf_ff;
   status_type  st_ff;

   dec_type     dec;
   logic [2:0]  e_count;
   logic [MaxUnits-1:0][UnitWidth-1:0] e_units;
   status_type  e_status;

   logic [7:0]  b;
   logic [15:0] w;
   logic [15:0] hi;
   logic        take, last_out, fire;

   assign csr_ready = 1'b1;
   assign b  = req_in_unit[7:0];
   assign w  = req_in_unit[15:0];
   assign hi = cp1252_hi(5'(b - 8'h80));

   assign last_out  = idx_ff == cnt_ff;
   assign req_stall = hold_ff && !(last_out && !rsp_stall);
   assign take      = req_valid && !req_stall;
   assign fire      = take && dec.emit;

   always_comb begin
      dec = '{emit: 1'b0, done: 1'b0, status: ST_OK, cp: '0};
      part_in = part_ff;
      pend_in = pend_ff;
      case (src_ff)
         ENC_ASCII: begin
            if (b > 8'h7f) dec.status = ST_INVALID;
            else begin dec.done = 1'b1; dec.cp = CpWidth'(b); end
         end
         ENC_UTF8: begin
            if (pend_ff == 2'd0) begin
               if (b <= 8'h7f) begin
                  dec.done = 1'b1; dec.cp = CpWidth'(b);
               end else if (b >= 8'hf0 && b <= 8'hf7) begin
                  part_in = CpWidth'(b[2:0]); pend_in = 2'd3;
               end else if (b >= 8'he0 && b <= 8'hef) begin
                  part_in = CpWidth'(b[3:0]); pend_in = 2'd2;
               end else if (b >= 8'hc0 && b <= 8'hdf) begin
                  part_in = CpWidth'(b[4:0]); pend_in = 2'd1;
               end else dec.status = ST_INVALID;
            end else if (b[7:6] != 2'b10) begin
               dec.status = ST_INVALID;
            end else begin
               part_in = {part_ff[CpWidth-7:0], b[5:0]};
               pend_in = pend_ff - 2'd1;
               if (pend_ff == 2'd1) begin dec.done = 1'b1; dec.cp = part_in; end
            end
         end
         ENC_UTF16: begin
            if (pend_ff == 2'd0) begin
               if (w[15:11] != 5'b11011) begin
                  dec.done = 1'b1; dec.cp = CpWidth'(w);
               end else if (!w[10]) begin
                  part_in = CpWidth'({w[9:0], 10'd0}); pend_in = 2'd1;
               end else dec.status = ST_INVALID;
            end else if (w[15:10] != 6'b110111) begin
               dec.status = ST_INVALID;
            end else begin
               dec.done = 1'b1;
               dec.cp = {part_ff[19:10], w[9:0]} + CpWidth'(20'h10000);
            end
         end
         ENC_UTF32: begin
            if (req_in_unit > 32'h10ffff) dec.status = ST_INVALID;
            else begin dec.done = 1'b1; dec.cp = CpWidth'(req_in_unit); end
         end
         ENC_CP1252: begin
            if (b <= 8'h7f || b >= 8'ha0) begin
               dec.done = 1'b1; dec.cp = CpWidth'(b);
            end else if (hi == 16'h0) dec.status = ST_INVALID;
            else begin dec.done = 1'b1; dec.cp = CpWidth'(hi); end
         end
         default: dec.status = ST_INVALID;
      endcase
      if (!dec.done && dec.status == ST_OK && req_end_of_text) begin
         dec.status = ST_TRUNCATED;
      end
      dec.emit = dec.done || dec.status != ST_OK;
      if (dec.emit) begin
         part_in = '0;
         pend_in = 2'd0;
      end
   end

   tetu_encoder u_enc (
      .target (tgt_ff),
      .dec    (dec),
      .count  (e_count),
      .units  (e_units),
      .status (e_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff  <= ENC_UTF8;
         tgt_ff  <= ENC_UTF16;
         part_ff <= '0;
         pend_ff <= 2'd0;
         hold_ff <= 1'b0;
         idx_ff  <= 3'd0;
         cnt_ff  <= 3'd0;
         st_ff   <= ST_OK;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_SOURCE) src_ff <= csr_data;
            else tgt_ff <= csr_data;
            part_ff <= '0;
            pend_ff <= 2'd0;
         end else if (take) begin
            part_ff <= part_in;
            pend_ff <= pend_in;
         end
         // advance through the held character, reload on the last unit
         if (hold_ff && !rsp_stall) begin
            idx_ff <= idx_ff + 3'd1;
            if (last_out) hold_ff <= 1'b0;
         end
         if (fire) begin
            hold_ff <= 1'b1;
            idx_ff  <= 3'd0;
            cnt_ff  <= e_count;
            st_ff   <= e_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) buf_ff <= e_units;
   end

   assign rsp_valid        = hold_ff;
   assign rsp_out_unit     = buf_ff[idx_ff[1:0]];
   assign rsp_last_of_char = last_out;
   assign rsp_status       = st_ff;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import tetu_pkg::*;

   typedef struct {
      logic [31:0] unit;
      logic        last;
      logic [1:0]  status;
   } out_unit_type;

   class transcode_board;
      logic [2:0]  src_enc;
      logic [2:0]  dst_enc;
      logic [20:0] partial;
      int          pending;
      out_unit_type expected_units[$];
      int          mismatches;

      function void reset_state();
         src_enc = ENC_UTF8;
         dst_enc = ENC_UTF16;
         partial = '0;
         pending = 0;
      endfunction

      function void set_reg(logic [0:0] idx, logic [2:0] val);
         if (idx == CSR_SOURCE) src_enc = val;
         else dst_enc = val;
         partial = '0;
         pending = 0;
      endfunction

      function void push(logic [31:0] u, logic l, status_type s);
         out_unit_type r;
         r.unit = u;
         r.last = l;
         r.status = s;
         expected_units.push_back(r);
      endfunction

      function void fail_char(status_type s);
         partial = '0;
         pending = 0;
         push(32'h0, 1'b1, s);
      endfunction

      function logic [15:0] cp1252_map(logic [4:0] idx);
         case (idx)
            5'd0: return 16'h20ac; 5'd2: return 16'h201a; 5'd3: return 16'h0192;
            5'd4: return 16'h201e; 5'd5: return 16'h2026; 5'd6: return 16'h2020;
            5'd7: return 16'h2021; 5'd8: return 16'h02c6; 5'd9: return 16'h2030;
            5'd10: return 16'h0160; 5'd11: return 16'h2039; 5'd12: return 16'h0152;
            5'd14: return 16'h017d; 5'd17: return 16'h2018; 5'd18: return 16'h2019;
            5'd19: return 16'h201c; 5'd20: return 16'h201d; 5'd21: return 16'h2022;
            5'd22: return 16'h2013; 5'd23: return 16'h2014; 5'd24: return 16'h02dc;
            5'd25: return 16'h2122; 5'd26: return 16'h0161; 5'd27: return 16'h203a;
            5'd28: return 16'h0153; 5'd30: return 16'h017e; 5'd31: return 16'h0178;
            default: return 16'h0;
         endcase
      endfunction

      function void encode_point(logic [31:0] cp);
         logic [31:0] v;
         case (dst_enc)
            ENC_ASCII: begin
               if (cp > 32'h7f) fail_char(ST_UNENCODE);
               else push(cp, 1, ST_OK);
            end
            ENC_UTF8: begin
               if (cp <= 32'h7f) push(cp, 1, ST_OK);
               else if (cp <= 32'h7ff) begin
                  push(32'hc0 | (cp >> 6), 0, ST_OK);
                  push(32'h80 | (cp & 32'h3f), 1, ST_OK);
               end else if (cp <= 32'hffff) begin
                  push(32'he0 | (cp >> 12), 0, ST_OK);
                  push(32'h80 | ((cp >> 6) & 32'h3f), 0, ST_OK);
                  push(32'h80 | (cp & 32'h3f), 1, ST_OK);
               end else if (cp > 32'h10ffff) fail_char(ST_UNENCODE);
               else begin
                  push(32'hf0 | (cp >> 18), 0, ST_OK);
                  push(32'h80 | ((cp >> 12) & 32'h3f), 0, ST_OK);
                  push(32'h80 | ((cp >> 6) & 32'h3f), 0, ST_OK);
                  push(32'h80 | (cp & 32'h3f), 1, ST_OK);
               end
            end
            ENC_UTF16: begin
               if (cp > 32'h10ffff || (cp >= 32'hd800 && cp <= 32'hdfff))
                  fail_char(ST_UNENCODE);
               else if (cp <= 32'hffff) push(cp, 1, ST_OK);
               else begin
                  v = cp - 32'h10000;
                  push(32'hd800 + ((v >> 10) & 32'h3ff), 0, ST_OK);
                  push(32'hdc00 + (v & 32'h3ff), 1, ST_OK);
               end
            end
            ENC_UTF32: begin
               if (cp > 32'h10ffff) fail_char(ST_UNENCODE);
               else push(cp, 1, ST_OK);
            end
            ENC_CP1252: begin
               if (cp <= 32'h7f || (cp >= 32'ha0 && cp <= 32'hff)) push(cp, 1, ST_OK);
               else begin
                  v = 32'hffff_ffff;
                  for (int i = 0; i < 32; i++)
                     if (cp1252_map(5'(i)) != 0 && cp1252_map(5'(i)) == cp) v = 32'h80 + i;
                  if (v != 32'hffff_ffff) push(v, 1, ST_OK);
                  else fail_char(ST_UNENCODE);
               end
            end
            default: fail_char(ST_UNENCODE);
         endcase
      endfunction

      // Decode one accepted item and queue the units it produces.
      function void note_item(logic [31:0] u, logic eot);
         logic [7:0]  b;
         logic [15:0] w;
         logic [31:0] cp;
         logic        done;
         b = u[7:0];
         w = u[15:0];
         cp = 0;
         done = 0;
         case (src_enc)
            ENC_ASCII: begin
               if (b > 8'h7f) begin fail_char(ST_INVALID); return; end
               cp = 32'(b);
               done = 1;
            end
            ENC_UTF8: begin
               if (pending == 0) begin
                  if (b <= 8'h7f) begin cp = 32'(b); done = 1; end
                  else if (b >= 8'hf0 && b <= 8'hf7) begin
                     partial = 21'(b[2:0]); pending = 3;
                  end else if (b >= 8'he0 && b <= 8'hef) begin
                     partial = 21'(b[3:0]); pending = 2;
                  end else if (b >= 8'hc0 && b <= 8'hdf) begin
                     partial = 21'(b[4:0]); pending = 1;
                  end else begin fail_char(ST_INVALID); return; end
               end else begin
                  if (b < 8'h80 || b > 8'hbf) begin fail_char(ST_INVALID); return; end
                  partial = {partial[14:0], b[5:0]};
                  pending = pending - 1;
                  if (pending == 0) begin cp = 32'(partial); done = 1; end
               end
            end
            ENC_UTF16: begin
               if (pending == 0) begin
                  if (w < 16'hd800 || w > 16'hdfff) begin cp = 32'(w); done = 1; end
                  else if (w <= 16'hdbff) begin partial = w[9:0] << 10; pending = 1; end
                  else begin fail_char(ST_INVALID); return; end
               end else begin
                  if (w < 16'hdc00 || w > 16'hdfff) begin fail_char(ST_INVALID); return; end
                  cp = (partial & 21'hffc00) + w[9:0] + 32'h10000;
                  pending = 0;
                  done = 1;
               end
            end
            ENC_UTF32: begin
               if (u > 32'h10ffff) begin fail_char(ST_INVALID); return; end
               cp = u;
               done = 1;
            end
            ENC_CP1252: begin
               if (b <= 8'h7f || b >= 8'ha0) cp = 32'(b);
               else begin
                  cp = 32'(cp1252_map(b[4:0]));
                  if (cp == 0) begin fail_char(ST_INVALID); return; end
               end
               done = 1;
            end
            default: begin fail_char(ST_INVALID); return; end
         endcase
         if (!done) begin
            if (eot) fail_char(ST_TRUNCATED);
            return;
         end
         partial = '0;
         pending = 0;
         encode_point(cp);
      endfunction

      function void check_unit(logic [31:0] u, logic l, logic [1:0] s);
         out_unit_type e;
         if (expected_units.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: unit %h last %b status %0d", u, l, s);
            return;
         end
         e = expected_units.pop_front();
         if (e.unit !== u || e.last !== l || e.status !== s) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp unit %h last %b status %0d, got %h %b %0d",
                        e.unit, e.last, e.status, u, l, s);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_in_unit = 0;
   logic        req_end_of_text = 0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic [31:0] rsp_out_unit;
   logic        rsp_last_of_char;
   logic [1:0]  rsp_status;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [0:0]  csr_index = 0;
   logic [2:0]  csr_data = 0;

   transcode_board board = new();
   bit   sender_done = 0;
   bit   hold_long = 0;
   int   cycles = 0;

   text_encoding_transcoder_unit uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: random stall, and one long hold-off.
   initial begin
      int gap;
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_stall <= 1;
            hold = 0;
            while (hold < 200) begin @(posedge clock); hold++; end
            rsp_stall <= 0;
            hold_long = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_unit(rsp_out_unit, rsp_last_of_char, rsp_status);

   task automatic send_unit(logic [31:0] u, logic eot, bit gaps = 1);
      int gap;
      if (gaps && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_in_unit <= u;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(u, eot);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.expected_units.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Leave valid high; the caller drops it after the last write.
   task automatic write_reg(logic [0:0] idx, logic [2:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, val);
   endtask

   task automatic set_codes(logic [2:0] s, logic [2:0] d);
      drain();
      write_reg(CSR_SOURCE, s);
      write_reg(CSR_TARGET, d);
      csr_valid <= 0;
   endtask

   // Random well-formed character in the source encoding, sometimes broken.
   task automatic send_random_char();
      logic [31:0] cp;
      logic [31:0] hi;
      logic        eot;
      int          r;
      r = $urandom_range(0, 3);
      cp = (r == 0) ? $urandom_range(0, 8'hff) : (r == 1) ? $urandom_range(0, 16'hffff) :
           $urandom_range(0, 32'h10ffff);
      eot = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 7) == 0) begin
         send_unit($urandom(), eot);
         return;
      end
      case (board.src_enc)
         ENC_UTF8: begin
            if (cp <= 32'h7f) send_unit({8'($urandom_range(0, 255)), 16'h0, cp[7:0]}, eot);
            else if (cp <= 32'h7ff) begin
               send_unit(32'hc0 | (cp >> 6), 0);
               send_unit(32'h80 | (cp & 32'h3f), eot);
            end else if (cp <= 32'hffff) begin
               send_unit(32'he0 | (cp >> 12), 0);
               send_unit(32'h80 | ((cp >> 6) & 32'h3f), eot);
               if (!eot) send_unit(32'h80 | (cp & 32'h3f), 0);
            end else begin
               send_unit(32'hf0 | (cp >> 18), 0);
               send_unit(32'h80 | ((cp >> 12) & 32'h3f), 0);
               send_unit(32'h80 | ((cp >> 6) & 32'h3f), 0);
               send_unit(32'h80 | (cp & 32'h3f), eot);
            end
         end
         ENC_UTF16: begin
            if (cp > 32'hffff) begin
               hi = cp - 32'h10000;
               send_unit({16'($urandom_range(0, 65535)), 16'(16'hd800 + hi[19:10])}, eot);
               if (!eot) send_unit(32'hdc00 + hi[9:0], 1'($urandom_range(0, 1)));
            end else send_unit({16'($urandom_range(0, 65535)), cp[15:0]}, eot);
         end
         ENC_UTF32: send_unit(($urandom_range(0, 9) == 0) ? $urandom() : cp, eot);
         default: send_unit({24'($urandom_range(0, 32'hffffff)), cp[7:0]}, eot);
      endcase
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      board.reset_state();
      @(posedge clock);

      // Directed: UTF-8 source into UTF-16 target (reset codes).
      send_unit(32'h0000_0041, 0);
      send_unit(32'hffff_ff7f, 0);
      send_unit(32'h80, 0);
      send_unit(32'hf8, 0);
      send_unit(32'hc3, 0);
      send_unit(32'h41, 0);
      send_unit(32'hf4, 0);
      send_unit(32'h8f, 0);
      send_unit(32'hbf, 0);
      send_unit(32'hbf, 0);
      send_unit(32'hf7, 0);
      send_unit(32'hbf, 0);
      send_unit(32'hbf, 0);
      send_unit(32'hbf, 0);
      send_unit(32'hed, 0);
      send_unit(32'ha0, 0);
      send_unit(32'h80, 0);
      send_unit(32'he2, 1);
      set_codes(ENC_UTF16, ENC_UTF8);
      send_unit(32'hffff_dbff, 0);
      send_unit(32'h0000_dfff, 0);
      send_unit(32'hdc00, 0);
      send_unit(32'hd800, 0);
      send_unit(32'h0041, 0);
      send_unit(32'hffff, 0);
      send_unit(32'hd800, 1);
      set_codes(ENC_CP1252, ENC_ASCII);
      for (int i = 8'h7f; i <= 8'h81; i++) send_unit(i, 0);
      send_unit(32'h9d, 0);
      set_codes(ENC_UTF32, ENC_CP1252);
      send_unit(32'h20ac, 0);
      send_unit(32'hffff_ffff, 0);
      send_unit(32'h110000, 0);
      send_unit(32'h10ffff, 0);
      send_unit(32'hff, 0);
      set_codes(3'd7, 3'd5);
      send_unit(32'h41, 0);
      set_codes(ENC_ASCII, 3'd6);
      send_unit(32'h41, 0);
      send_unit(32'h80, 0);

      // Long receiver hold-off so the block backs up.
      set_codes(ENC_UTF8, ENC_UTF32);
      hold_long = 1;
      for (int i = 0; i < 12; i++) send_unit(32'h30 + i, 0, 0);

      for (int ph = 0; ph < 8; ph++) begin
         set_codes(3'($urandom_range(0, 4)), 3'($urandom_range(0, 4)));
         for (int n = 0; n < 8; n++) send_random_char();
      end
      set_codes(ENC_UTF8, ENC_UTF8);
      for (int n = 0; n < 8; n++) send_random_char();

      drain();
      if (board.mismatches == 0 && board.expected_units.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/tetu_pkg.sv
hw/rtl/tetu_encoder.sv
hw/rtl/text_encoding_transcoder_unit.sv
dv/tb_top.sv
